// File: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared constants for the segment crossing test block.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int THR_BITS       = 16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd66;

endpackage

// File: hdl/segment_crossing_test_top.sv
// ----------------------------------------------------------------------------
// segment_crossing_test_top
// Data passes the divider stages, then the slope, product, intercept, span
// and output registers; the slope dividers give one quotient bit per stage
// and set the depth. Throughput: one transaction per cycle; the whole
// pipeline holds while the output register is full and not taken.
// Reset empties the pipeline and loads the threshold with its default.
// ----------------------------------------------------------------------------
module segment_crossing_test_top #(
    parameter int COORD_BITS = sct_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sct_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]       i_s_tdata,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // collide
    output logic [7:0]                              o_m_tdata,
    input  logic                                    i_cfg_we,
    input  logic [sct_pkg::THR_BITS-1:0]            i_cfg_wdata
);
    import sct_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int FW = FRAC_BITS;
    localparam int NB = CW + FW + 1;
    localparam int DB = CW + 1;
    localparam int SW = NB + 1;
    localparam int PW = CW + SW;
    localparam int NW = CW + SW + 3;

    typedef struct packed {
        logic [NB-1:0] num;
        logic [DB-1:0] den;
        logic [DB:0]   rem;
        logic [NB-1:0] quo;
        logic          neg;
    } t_div;

    typedef struct packed {
        t_div                 da;
        t_div                 db;
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay0;
        logic signed [CW-1:0] bx0;
        logic signed [CW-1:0] bx1;
        logic signed [CW-1:0] by0;
        logic                 vert;
    } t_stage;

    function automatic t_div div_step(t_div d, int idx);
        logic [DB:0] t;
        t_div        r;
        r = d;
        t = {d.rem[DB-1:0], d.num[idx]};
        if (t >= {1'b0, d.den}) begin
            r.rem = t - {1'b0, d.den};
            r.quo[idx] = 1'b1;
        end else begin
            r.rem = t;
            r.quo[idx] = 1'b0;
        end
        return r;
    endfunction

    function automatic t_div div_init(logic signed [CW-1:0] x0, logic signed [CW-1:0] y0,
                                      logic signed [CW-1:0] x1, logic signed [CW-1:0] y1);
        logic signed [DB-1:0] dx;
        logic signed [DB-1:0] dy;
        logic [DB-1:0]        mx;
        logic [DB-1:0]        my;
        t_div                 r;
        dx = DB'(x1) - DB'(x0);
        dy = DB'(y1) - DB'(y0);
        mx = dx[DB-1] ? DB'(-dx) : DB'(dx);
        my = dy[DB-1] ? DB'(-dy) : DB'(dy);
        r.num = NB'({my, {FW{1'b0}}});
        r.den = mx;
        r.rem = '0;
        r.quo = '0;
        r.neg = dx[DB-1] ^ dy[DB-1];
        return r;
    endfunction

    logic                  adv;
    logic [THR_BITS-1:0]   r_thr;
    logic [NB:0]           r_v;
    t_stage                r_st [0:NB];
    t_stage                n_st0;

    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_st0.ax0  = i_s_tdata[0*CW +: CW];
        n_st0.ay0  = i_s_tdata[1*CW +: CW];
        n_st0.ax1  = i_s_tdata[2*CW +: CW];
        n_st0.bx0  = i_s_tdata[4*CW +: CW];
        n_st0.by0  = i_s_tdata[5*CW +: CW];
        n_st0.bx1  = i_s_tdata[6*CW +: CW];
        n_st0.da   = div_init(i_s_tdata[0*CW +: CW], i_s_tdata[1*CW +: CW],
                              i_s_tdata[2*CW +: CW], i_s_tdata[3*CW +: CW]);
        n_st0.db   = div_init(i_s_tdata[4*CW +: CW], i_s_tdata[5*CW +: CW],
                              i_s_tdata[6*CW +: CW], i_s_tdata[7*CW +: CW]);
        n_st0.vert = (i_s_tdata[0*CW +: CW] == i_s_tdata[2*CW +: CW]) ||
                     (i_s_tdata[4*CW +: CW] == i_s_tdata[6*CW +: CW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NB-1:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= n_st0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= NB; k++) begin : g_div
            t_stage n_st;
            always_comb begin
                n_st    = r_st[k-1];
                n_st.da = div_step(r_st[k-1].da, NB - k);
                n_st.db = div_step(r_st[k-1].db, NB - k);
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_st[k] <= n_st;
                end
            end
        end
    endgenerate

    // Slopes, difference and the overlap of the x-spans.
    logic signed [SW-1:0]   n_as, n_bs;
    logic signed [SW:0]     n_diff;
    logic [SW:0]            n_absd;
    logic signed [CW-1:0]   n_lo, n_hi, a_lo, a_hi, b_lo, b_hi;
    logic                   n_kill1;
    logic                   r_v1;
    logic signed [SW-1:0]   r_as, r_bs;
    logic [SW:0]            r_den1;
    logic                   r_neg1, r_kill1;
    logic signed [CW-1:0]   r_lo1, r_hi1, r_ax0, r_ay0, r_bx0, r_by0;

    always_comb begin
        n_as   = r_st[NB].da.neg ? -$signed(SW'(r_st[NB].da.quo))
                                 :  $signed(SW'(r_st[NB].da.quo));
        n_bs   = r_st[NB].db.neg ? -$signed(SW'(r_st[NB].db.quo))
                                 :  $signed(SW'(r_st[NB].db.quo));
        n_diff = (SW+1)'(n_as) - (SW+1)'(n_bs);
        n_absd = n_diff[SW] ? (SW+1)'(-n_diff) : (SW+1)'(n_diff);
        a_lo   = (r_st[NB].ax0 < r_st[NB].ax1) ? r_st[NB].ax0 : r_st[NB].ax1;
        a_hi   = (r_st[NB].ax0 < r_st[NB].ax1) ? r_st[NB].ax1 : r_st[NB].ax0;
        b_lo   = (r_st[NB].bx0 < r_st[NB].bx1) ? r_st[NB].bx0 : r_st[NB].bx1;
        b_hi   = (r_st[NB].bx0 < r_st[NB].bx1) ? r_st[NB].bx1 : r_st[NB].bx0;
        n_lo   = (a_lo > b_lo) ? a_lo : b_lo;
        n_hi   = (a_hi < b_hi) ? a_hi : b_hi;
        n_kill1 = r_st[NB].vert || (n_absd == '0) ||
                  (n_absd < (SW+1)'(r_thr)) || (n_lo > n_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_v[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_as    <= n_as;
            r_bs    <= n_bs;
            r_den1  <= n_absd;
            r_neg1  <= n_diff[SW];
            r_kill1 <= n_kill1;
            r_lo1   <= n_lo;
            r_hi1   <= n_hi;
            r_ax0   <= r_st[NB].ax0;
            r_ay0   <= r_st[NB].ay0;
            r_bx0   <= r_st[NB].bx0;
            r_by0   <= r_st[NB].by0;
        end
    end

    // Products x0 * slope.
    logic                   r_v2, r_neg2, r_kill2;
    logic signed [PW-1:0]   r_pa, r_pb;
    logic signed [CW-1:0]   r_ay2, r_by2, r_lo2, r_hi2;
    logic [SW:0]            r_den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa    <= PW'(r_ax0) * PW'(r_as);
            r_pb    <= PW'(r_bx0) * PW'(r_bs);
            r_ay2   <= r_ay0;
            r_by2   <= r_by0;
            r_lo2   <= r_lo1;
            r_hi2   <= r_hi1;
            r_den2  <= r_den1;
            r_neg2  <= r_neg1;
            r_kill2 <= r_kill1;
        end
    end

    // Intercept difference, sign-corrected against the slope difference.
    logic signed [NW-1:0]   n_aoff, n_boff, n_num;
    logic                   r_v3, r_kill3;
    logic signed [NW-1:0]   r_num3;
    logic signed [CW-1:0]   r_lo3, r_hi3;
    logic [SW:0]            r_den3;

    always_comb begin
        n_aoff = (NW'(r_ay2) <<< FW) - NW'(r_pa);
        n_boff = (NW'(r_by2) <<< FW) - NW'(r_pb);
        n_num  = r_neg2 ? (n_aoff - n_boff) : (n_boff - n_aoff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num3  <= n_num;
            r_lo3   <= r_lo2;
            r_hi3   <= r_hi2;
            r_den3  <= r_den2;
            r_kill3 <= r_kill2;
        end
    end

    // Span bounds scaled by the slope difference.
    logic                   r_v4, r_kill4;
    logic signed [NW-1:0]   r_num4, r_plo, r_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_plo   <= NW'(r_lo3) * $signed(NW'(r_den3));
            r_phi   <= NW'(r_hi3) * $signed(NW'(r_den3));
            r_num4  <= r_num3;
            r_kill4 <= r_kill3;
        end
    end

    // Output register.
    logic r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (adv) begin
            o_m_tvalid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_col <= !r_kill4 && (r_plo <= r_num4) && (r_num4 <= r_phi);
        end
    end

    assign o_m_tdata = {7'd0, r_col};

    a_rst_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
    a_hold_pipe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_v) && $stable(r_v4))
        else $error("pipeline moved during a stall");
    a_kill_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v4 && r_kill4) |=> !r_col)
        else $error("collision reported for a rejected pair");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Segment crossing test bench
// Drives segment pairs into the crossing test, predicts each collide flag
// with an exact fixed point model, and checks the results in order under
// random idling on both sides and several thresholds set one after another.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CB = sct_pkg::COORD_BITS_DEF;
    localparam int FB = sct_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = CB + FB + 7;

    typedef struct packed {
        logic signed [15:0] by1, bx1, by0, bx0, ay1, ax1, ay0, ax0;
    } t_seg_pair;

    typedef struct {
        t_seg_pair p;
        logic      known;
        logic      flag;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [7:0]   o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;

    logic [15:0]  threshold = sct_pkg::THR_RESET;
    logic         collide_q[$];
    int           errors = 0;
    int           results = 0;
    int           hits = 0;
    bit           calm = 0;
    t_row         rows[$];

    segment_crossing_test_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic predict_collide(t_seg_pair p, logic [15:0] thr);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint sa, sb, d, lo, hi;
        logic signed [127:0] aoff, boff, num, den;
        begin
            ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
            bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
            if (ax0 == ax1 || bx0 == bx1) return 1'b0;
            sa = ((ay1 - ay0) <<< FB) / (ax1 - ax0);
            sb = ((by1 - by0) <<< FB) / (bx1 - bx0);
            d = sa - sb;
            if (d < 0) d = -d;
            if (d == 0 || d < longint'(thr)) return 1'b0;
            aoff = (128'(signed'(ay0)) <<< FB) - 128'(signed'(ax0)) * 128'(signed'(sa));
            boff = (128'(signed'(by0)) <<< FB) - 128'(signed'(bx0)) * 128'(signed'(sb));
            num = boff - aoff;
            den = 128'(signed'(sa - sb));
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            lo = (ax0 < ax1 ? ax0 : ax1);
            if ((bx0 < bx1 ? bx0 : bx1) > lo) lo = (bx0 < bx1 ? bx0 : bx1);
            hi = (ax0 < ax1 ? ax1 : ax0);
            if ((bx0 < bx1 ? bx1 : bx0) < hi) hi = (bx0 < bx1 ? bx1 : bx0);
            if (lo > hi) return 1'b0;
            return (128'(signed'(lo)) * den <= num) && (num <= 128'(signed'(hi)) * den);
        end
    endfunction

    function automatic logic signed [15:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return 16'sh8000 + 16'($urandom_range(0, 3));
            1: return 16'sh7fff - 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_seg_pair rnd_pair();
        t_seg_pair p;
        int c;
        begin
            p = {8{16'h0}};
            c = $urandom_range(0, 9);
            if (c < 2) begin
                p = t_seg_pair'({$urandom, $urandom, $urandom, $urandom});
            end else begin
                // Crossing-oriented pairs: for c < 7 segment b's x ends lie within two of segment a's.
                p.ax0 = rnd_coord(); p.ax1 = rnd_coord();
                p.ay0 = rnd_coord(); p.ay1 = rnd_coord();
                p.bx0 = (c < 7) ? p.ax0 + 16'($urandom_range(0, 4)) - 16'sd2 : rnd_coord();
                p.bx1 = (c < 7) ? p.ax1 + 16'($urandom_range(0, 4)) - 16'sd2 : rnd_coord();
                p.by0 = (c < 5) ? p.ay1 : rnd_coord();
                p.by1 = (c < 5) ? p.ay0 : rnd_coord();
                if (c == 9) p.bx1 = p.bx0;
            end
            return p;
        end
    endfunction

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    task automatic send_pair(t_seg_pair p);
        i_s_tdata <= p;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        collide_q.push_back(predict_collide(p, threshold));
        @(negedge i_clk);
    endtask

    task automatic drain_and_set(logic [15:0] thr);
        int guard;
        begin
            guard = 0;
            i_s_tvalid <= 1'b0;
            while (collide_q.size() != 0 && guard < 200000) begin
                @(negedge i_clk);
                guard++;
            end
            repeat (LATENCY + 4) @(negedge i_clk);
            i_cfg_wdata <= thr;
            i_cfg_we <= 1'b1;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            threshold = thr;
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                i_m_tready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (collide_q.size() == 0) begin
                $error("collide: unexpected transaction, actual %0d", o_m_tdata[0]);
                errors++;
            end else begin
                if (o_m_tdata[0] !== collide_q[0]) begin
                    $error("collide: expected %0d actual %0d", collide_q[0], o_m_tdata[0]);
                    errors++;
                end
                if (o_m_tdata[7:1] !== 7'd0) begin
                    $error("tdata pad: expected 0 actual %0h", o_m_tdata[7:1]);
                    errors++;
                end
                hits += o_m_tdata[0];
                void'(collide_q.pop_front());
            end
            results++;
        end
    end

    function automatic t_row mk(logic [127:0] v, logic known, logic flag);
        t_row r;
        r.p = t_seg_pair'(v);
        r.known = known;
        r.flag = flag;
        return r;
    endfunction

    initial begin
        int guard;
        logic [15:0] thr_list[4];
        // Fields from low: ax0 ay0 ax1 ay1 bx0 by0 bx1 by1.
        rows.push_back(mk({16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd0},
                          1, 1));
        rows.push_back(mk({16'sd9, 16'sd5, 16'sd0, 16'sd5, 16'sd10, 16'sd10, 16'sd0, 16'sd0},
                          1, 0));
        rows.push_back(mk({16'sd5, 16'sd10, 16'sd5, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd0},
                          1, 1));
        rows.push_back(mk({16'sd3, 16'sd10, 16'sd1, 16'sd0, 16'sd2, 16'sd10, 16'sd0, 16'sd0},
                          1, 0));
        rows.push_back(mk({16'sd0, 16'sd20, 16'sd0, 16'sd15, 16'sd10, 16'sd10, 16'sd0, 16'sd0},
                          1, 0));
        rows.push_back(mk({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                           16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 0, 0));
        rows.push_back(mk({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                           16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}, 0, 0));
        rows.push_back(mk({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8001,
                           16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8001}, 0, 0));
        rows.push_back(mk({16'sd1, 16'sd1000, 16'sd0, 16'sd999, 16'sd1, 16'sd1, 16'sd0, 16'sd0},
                          0, 0));
        rows.push_back(mk({16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd0},
                          1, 0));
        rows.push_back(mk({16'hffff, 16'hffff, 16'hffff, 16'hffff,
                           16'hffff, 16'hfffe, 16'hffff, 16'hfffe}, 0, 0));
        thr_list[0] = 16'd0; thr_list[1] = 16'hffff;
        thr_list[2] = 16'd1; thr_list[3] = 16'($urandom);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].known && rows[i].flag !== predict_collide(rows[i].p, threshold)) begin
                $error("collide: table row %0d expected %0d predicted otherwise",
                       i, rows[i].flag);
                errors++;
            end
            idle_burst();
            send_pair(rows[i].p);
        end
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) drain_and_set(thr_list[ph - 1]);
            if (ph == 4) calm = 1;
            repeat (150) begin
                idle_burst();
                send_pair(rnd_pair());
            end
        end
        i_s_tvalid <= 1'b0;
        guard = 0;
        while (collide_q.size() != 0 && guard < 500000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (collide_q.size() != 0) begin
            $error("collide: %0d expected transactions never arrived", collide_q.size());
            errors++;
        end
        $display("Checked %0d results (%0d collisions) over five threshold settings.",
                 results, hits);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: segment_crossing_test_top.f
hdl/sct_pkg.sv
hdl/segment_crossing_test_top.sv
sim/testbench.sv
